// ----- src/log_snippet_entry_deframer_core_defines.svh -----
// Assertion macros shared by the deframer RTL.
`ifndef LOG_SNIPPET_ENTRY_DEFRAMER_CORE_DEFINES_SVH
`define LOG_SNIPPET_ENTRY_DEFRAMER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSED_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSED_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lsed_pkg.sv -----
package lsed_pkg;

    // Field widths of the stream items.
    localparam int BYTE_W    = 8;
    localparam int SIZE_W    = 32;
    localparam int SEQ_W     = 63;
    localparam int HASH_W    = 7;
    localparam int MOD_W     = 10;
    localparam int TDATA_W   = 120;
    localparam int FIELDS_W  = 115;
    localparam int SEQ_BYTES = 8;

    // Size codes that follow the type byte.
    localparam logic [7:0] CODE_HASHED = 8'h00;
    localparam logic [7:0] CODE_SIZE16 = 8'hFF;
    localparam logic [7:0] CODE_SIZE32 = 8'hFE;

    // Delta codes between entries.
    localparam logic [7:0] DELTA_INC    = 8'h00;
    localparam logic [7:0] DELTA_LOAD64 = 8'hFF;

    // Sequence numbers step in thousands for the coarse delta code.
    localparam logic [MOD_W-1:0] SEQ_STEP = 10'd1000;
    localparam logic [MOD_W-1:0] MOD_LAST = 10'd999;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HASH_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SEQ = 2'd1;
    localparam logic [HASH_W-1:0]    HASH_SIZE_RESET = 7'd20;

    // Result queue depth, a power of two of at least two.
    localparam int OUTQ_DEPTH_DEF = 4;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_PAYLOAD,
        KIND_DONE,
        KIND_ERROR
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_HEADER_CUT,
        ERR_ENTRY_CUT,
        ERR_NO_ENTRY,
        ERR_ROLLBACK
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  entry_type;
        logic [SIZE_W-1:0]  entry_size;
        logic               hashed;
        logic [SEQ_W-1:0]   seq;
        logic [BYTE_W-1:0]  payload;
        err_t               err;
        logic               last;
    } res_t;

    // One step of a running residue modulo 1000 over little-endian bytes:
    // adds byte b at position idx, weighted by 256^idx mod 1000, then folds
    // the sum back below 1000 using 1024 = 24 (mod 1000).
    function automatic logic [MOD_W-1:0] mod_step(input logic [MOD_W-1:0] acc,
                                                  input logic [BYTE_W-1:0] b,
                                                  input logic [2:0] idx);
        logic [9:0]  w;
        logic [17:0] x;
        logic [12:0] y;
        logic [10:0] z;
        case (idx)
            3'd0:    w = 10'd1;
            3'd1:    w = 10'd256;
            3'd2:    w = 10'd536;
            3'd3:    w = 10'd216;
            3'd4:    w = 10'd296;
            3'd5:    w = 10'd776;
            3'd6:    w = 10'd656;
            default: w = 10'd936;
        endcase
        x = 18'(acc) + 18'(b) * 18'(w);
        y = 13'(x[17:10]) * 13'd24 + 13'(x[9:0]);
        z = 11'(y[12:10]) * 11'd24 + 11'(y[9:0]);
        if (z >= 11'(SEQ_STEP))
            mod_step = MOD_W'(z - 11'(SEQ_STEP));
        else
            mod_step = z[MOD_W-1:0];
    endfunction

endpackage

// ----- src/lsed_cfg.sv -----
module lsed_cfg
    import lsed_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_W-1:0]     cfg_data,
    output logic [HASH_W-1:0]    hash_size,
    output logic [SEQ_W-1:0]     first_seq,
    output logic [MOD_W-1:0]     first_mod,
    output logic                 busy
);

    localparam int CNT_W = $clog2(SEQ_BYTES + 1);

    logic [HASH_W-1:0] hash_size_reg;
    logic [SEQ_W-1:0]  first_seq_reg;
    logic [MOD_W-1:0]  mod_acc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [2:0]        byte_idx;
    logic [63:0]       seq_ext;
    logic [BYTE_W-1:0] cur_byte;

    // Byte of the stored start sequence that the residue sweep takes next.
    assign busy     = (cnt_reg != '0);
    assign byte_idx = 3'(CNT_W'(SEQ_BYTES) - cnt_reg);
    assign seq_ext  = {1'b0, first_seq_reg};
    assign cur_byte = seq_ext[{byte_idx, 3'b000} +: BYTE_W];

    // Register writes; a start sequence write launches a sweep that leaves
    // its residue modulo 1000 in mod_acc_reg.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_size_reg <= HASH_SIZE_RESET;
            first_seq_reg <= '0;
            mod_acc_reg   <= '0;
            cnt_reg       <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HASH_SIZE:
                begin
                    hash_size_reg <= cfg_data[HASH_W-1:0];
                end
                REG_FIRST_SEQ:
                begin
                    first_seq_reg <= cfg_data;
                    mod_acc_reg   <= '0;
                    cnt_reg       <= CNT_W'(SEQ_BYTES);
                end
                default:
                begin
                end
            endcase
        end
        else if (busy)
        begin
            mod_acc_reg <= mod_step(mod_acc_reg, cur_byte, byte_idx);
            cnt_reg     <= cnt_reg - CNT_W'(1);
        end
    end

    assign cfg_ready = !busy;
    assign hash_size = hash_size_reg;
    assign first_seq = first_seq_reg;
    assign first_mod = mod_acc_reg;

endmodule

// ----- src/lsed_parse.sv -----
module lsed_parse
    import lsed_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] data_byte,
    input  logic              final_byte,
    input  logic [HASH_W-1:0] hash_size,
    input  logic [SEQ_W-1:0]  first_seq,
    input  logic [MOD_W-1:0]  first_mod,
    output res_t              res_a,
    output res_t              res_b,
    output logic [1:0]        res_cnt
);

    typedef enum logic [2:0] {
        PH_START,
        PH_TYPE,
        PH_CODE,
        PH_SIZE16,
        PH_SIZE32,
        PH_PAYLOAD,
        PH_DELTA,
        PH_DELTA64
    } phase_t;

    localparam logic [2:0] SIZE16_MORE = 3'd1;
    localparam logic [2:0] SIZE32_MORE = 3'd3;
    localparam logic [2:0] SEQ64_MORE  = 3'd7;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] type_reg, type_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [SIZE_W-1:0] left_reg, left_next;
    logic [2:0]        fbl_reg, fbl_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [MOD_W-1:0]  mod_reg, mod_next;
    logic [63:0]       sacc_reg, sacc_next;
    logic [MOD_W-1:0]  macc_reg, macc_next;
    logic              hold_reg, hold_next;
    logic              hashed_reg, hashed_next;

    logic              v0, v1;
    kind_t             k0, k1;
    err_t              e0, e1;
    logic              rollback;
    logic              start_ent, end_ent, apply;
    logic [63:0]       new_seq;
    logic [MOD_W-1:0]  new_mod;
    logic [SIZE_W-1:0] left_dec;
    logic [63:0]       acc_new;
    logic [MOD_W-1:0]  macc_new;
    logic [1:0]        size_idx;
    logic [2:0]        seq_idx;
    logic [BYTE_W-1:0] pay_byte;

    // Byte positions inside the multi-byte size and sequence fields.
    assign size_idx = ((phase_reg == PH_SIZE16) ? 2'd1 : 2'd3) - fbl_reg[1:0];
    assign seq_idx  = SEQ64_MORE - fbl_reg;
    assign acc_new  = sacc_reg | (64'(data_byte) << {seq_idx, 3'b000});
    assign macc_new = mod_step(macc_reg, data_byte, seq_idx);
    assign left_dec = left_reg - SIZE_W'(left_reg != '0);

    // One snippet byte: next state and up to two results.
    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        size_next   = size_reg;
        left_next   = left_reg;
        fbl_next    = fbl_reg;
        seq_next    = seq_reg;
        mod_next    = mod_reg;
        sacc_next   = sacc_reg;
        macc_next   = macc_reg;
        hold_next   = hold_reg;
        hashed_next = hashed_reg;
        v0          = 1'b0;
        v1          = 1'b0;
        k0          = KIND_HEADER;
        k1          = KIND_HEADER;
        e0          = ERR_NONE;
        e1          = ERR_NONE;
        rollback    = 1'b0;
        start_ent   = 1'b0;
        end_ent     = 1'b0;
        apply       = 1'b0;
        new_seq     = '0;
        new_mod     = '0;
        pay_byte    = '0;

        if (step && !hold_reg)
        begin
            case (phase_reg)
                PH_START, PH_TYPE:
                begin
                    if (phase_reg == PH_START)
                    begin
                        seq_next = first_seq;
                        mod_next = first_mod;
                    end
                    type_next   = data_byte;
                    size_next   = '0;
                    hashed_next = 1'b0;
                    phase_next  = PH_CODE;
                    if (final_byte)
                    begin
                        v0 = 1'b1;
                        k0 = KIND_ERROR;
                        e0 = ERR_HEADER_CUT;
                    end
                end
                PH_CODE:
                begin
                    if (data_byte == CODE_SIZE16 || data_byte == CODE_SIZE32)
                    begin
                        phase_next = (data_byte == CODE_SIZE16) ? PH_SIZE16 : PH_SIZE32;
                        fbl_next   = (data_byte == CODE_SIZE16) ? SIZE16_MORE : SIZE32_MORE;
                        if (final_byte)
                        begin
                            v0 = 1'b1;
                            k0 = KIND_ERROR;
                            e0 = ERR_HEADER_CUT;
                        end
                    end
                    else
                    begin
                        hashed_next = (data_byte == CODE_HASHED);
                        size_next   = (data_byte == CODE_HASHED) ? SIZE_W'(hash_size)
                                                                 : SIZE_W'(data_byte);
                        start_ent   = 1'b1;
                    end
                end
                PH_SIZE16, PH_SIZE32:
                begin
                    size_next = size_reg | (SIZE_W'(data_byte) << {size_idx, 3'b000});
                    if (fbl_reg == '0)
                    begin
                        start_ent = 1'b1;
                    end
                    else
                    begin
                        fbl_next = fbl_reg - 3'd1;
                        if (final_byte)
                        begin
                            v0 = 1'b1;
                            k0 = KIND_ERROR;
                            e0 = ERR_HEADER_CUT;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    v0        = 1'b1;
                    k0        = KIND_PAYLOAD;
                    pay_byte  = data_byte;
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        end_ent = 1'b1;
                    end
                    else if (final_byte)
                    begin
                        v1 = 1'b1;
                        k1 = KIND_ERROR;
                        e1 = ERR_ENTRY_CUT;
                    end
                end
                PH_DELTA:
                begin
                    if (data_byte == DELTA_LOAD64)
                    begin
                        phase_next = PH_DELTA64;
                        fbl_next   = SEQ64_MORE;
                        sacc_next  = '0;
                        macc_next  = '0;
                        if (final_byte)
                        begin
                            v0 = 1'b1;
                            k0 = KIND_ERROR;
                            e0 = ERR_NO_ENTRY;
                        end
                    end
                    else if (data_byte == DELTA_INC)
                    begin
                        apply   = 1'b1;
                        new_seq = {1'b0, seq_reg} + 64'd1;
                        new_mod = (mod_reg == MOD_LAST) ? '0 : mod_reg + MOD_W'(1);
                    end
                    else
                    begin
                        apply   = 1'b1;
                        new_seq = {1'b0, seq_reg} - 64'(mod_reg)
                                  + 64'(18'(data_byte) * 18'(SEQ_STEP));
                        new_mod = '0;
                    end
                end
                PH_DELTA64:
                begin
                    sacc_next = acc_new;
                    macc_next = macc_new;
                    if (fbl_reg == '0)
                    begin
                        apply   = 1'b1;
                        new_seq = acc_new;
                        new_mod = macc_new;
                    end
                    else
                    begin
                        fbl_next = fbl_reg - 3'd1;
                        if (final_byte)
                        begin
                            v0 = 1'b1;
                            k0 = KIND_ERROR;
                            e0 = ERR_NO_ENTRY;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            // Size field complete: header, then payload or an empty entry.
            if (start_ent)
            begin
                v0        = 1'b1;
                k0        = KIND_HEADER;
                left_next = size_next;
                if (size_next == '0)
                begin
                    end_ent = 1'b1;
                end
                else
                begin
                    phase_next = PH_PAYLOAD;
                    if (final_byte)
                    begin
                        v1 = 1'b1;
                        k1 = KIND_ERROR;
                        e1 = ERR_ENTRY_CUT;
                    end
                end
            end

            // Entry complete: close the snippet or wait for a delta code.
            if (end_ent)
            begin
                if (final_byte)
                begin
                    v1 = 1'b1;
                    k1 = KIND_DONE;
                end
                else
                begin
                    phase_next = PH_DELTA;
                end
            end

            // New sequence number must rise and fit in 63 bits.
            if (apply)
            begin
                if (new_seq[63] || new_seq <= {1'b0, seq_reg})
                begin
                    v0       = 1'b1;
                    k0       = KIND_ERROR;
                    e0       = ERR_ROLLBACK;
                    rollback = 1'b1;
                end
                else
                begin
                    seq_next   = new_seq[SEQ_W-1:0];
                    mod_next   = new_mod;
                    phase_next = PH_TYPE;
                    if (final_byte)
                    begin
                        v0 = 1'b1;
                        k0 = KIND_ERROR;
                        e0 = ERR_NO_ENTRY;
                    end
                end
            end

            hold_next = (v0 && k0 == KIND_ERROR) || (v1 && k1 == KIND_ERROR);
        end

        // The last byte of a snippet always returns to snippet start.
        if (step && final_byte)
        begin
            phase_next = PH_START;
            hold_next  = 1'b0;
            fbl_next   = '0;
            left_next  = '0;
        end
    end

    // Results carry the entry fields as updated by this byte.
    always_comb
    begin
        res_a.kind       = k0;
        res_a.entry_type = type_next;
        res_a.entry_size = size_next;
        res_a.hashed     = hashed_next;
        res_a.seq        = rollback ? new_seq[SEQ_W-1:0] : seq_next;
        res_a.payload    = pay_byte;
        res_a.err        = e0;
        res_a.last       = !v1;
        res_b.kind       = k1;
        res_b.entry_type = type_next;
        res_b.entry_size = size_next;
        res_b.hashed     = hashed_next;
        res_b.seq        = seq_next;
        res_b.payload    = '0;
        res_b.err        = e1;
        res_b.last       = 1'b1;
        res_cnt          = {1'b0, v0} + {1'b0, v1};
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_START;
            type_reg   <= '0;
            size_reg   <= '0;
            left_reg   <= '0;
            fbl_reg    <= '0;
            seq_reg    <= '0;
            mod_reg    <= '0;
            sacc_reg   <= '0;
            macc_reg   <= '0;
            hold_reg   <= 1'b0;
            hashed_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            size_reg   <= size_next;
            left_reg   <= left_next;
            fbl_reg    <= fbl_next;
            seq_reg    <= seq_next;
            mod_reg    <= mod_next;
            sacc_reg   <= sacc_next;
            macc_reg   <= macc_next;
            hold_reg   <= hold_next;
            hashed_reg <= hashed_next;
        end
    end

endmodule

// ----- src/lsed_outq.sv -----
module lsed_outq
    import lsed_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  res_t       wr_a,
    input  res_t       wr_b,
    input  logic [1:0] wr_cnt,
    output logic       room2,
    output res_t       rd_data,
    output logic       rd_valid,
    input  logic       rd_ready
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t          mem_reg [DEPTH];
    logic [PW-1:0] wp_reg;
    logic [PW-1:0] rp_reg;
    logic [CW-1:0] cnt_reg;
    logic          pop;

    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign pop      = rd_valid && rd_ready;
    assign room2    = (cnt_reg <= CW'(DEPTH - 2));

    // Result storage: up to two writes per byte, one read per request.
    always_ff @(posedge clk)
    begin
        if (wr_cnt != 2'd0)
        begin
            mem_reg[wp_reg] <= wr_a;
        end
        if (wr_cnt == 2'd2)
        begin
            mem_reg[wp_reg + PW'(1)] <= wr_b;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + PW'(wr_cnt);
            rp_reg  <= rp_reg + PW'(pop);
            cnt_reg <= cnt_reg + CW'(wr_cnt) - CW'(pop);
        end
    end

endmodule

// ----- src/log_snippet_entry_deframer_core.sv -----
// Log snippet entry deframer. Snippet bytes enter on the slave stream with
// tlast on the final byte; each entry yields a header request, one request per
// payload byte, and a closing request (ended correctly or error) at the end of
// the snippet. A byte is registered on entry and parsed from that register, so
// one byte per cycle is accepted as long as the result queue has room for
// two requests; a byte that yields two results (header or payload plus the
// closing request) is delivered as two results on the master side, and the
// sustained rate is then set by the master handshake, one result per cycle. A
// write to the first sequence register starts a sweep that derives its residue
// modulo 1000; no byte and no further write is taken during it.
`include "log_snippet_entry_deframer_core_defines.svh"

module log_snippet_entry_deframer_core
    import lsed_pkg::*;
#(
    parameter int OUTQ_DEPTH = OUTQ_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // tdata: data_byte [7:0]
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,
    input  logic                 s_axis_tlast,
    // tdata: entry_type [7:0], entry_size [39:8], hashed [40],
    //        sequence_res [103:41], payload_byte [111:104],
    //        error_code [114:112], zero [119:115]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,
    // tuser: kind [1:0]
    output logic [1:0]           m_axis_tuser,
    output logic                 m_axis_tlast,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_W-1:0]     cfg_data
);

    logic              in_vld_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_fin_reg;
    logic              fire;
    logic              room2;
    logic              cfg_busy;
    logic [HASH_W-1:0] hash_size;
    logic [SEQ_W-1:0]  first_seq;
    logic [MOD_W-1:0]  first_mod;
    res_t              res_a;
    res_t              res_b;
    logic [1:0]        res_cnt;
    res_t              head;

    // Parse the registered byte when the queue can take both results and no sweep runs.
    assign fire          = in_vld_reg && room2 && !cfg_busy;
    assign s_axis_tready = !cfg_busy && (!in_vld_reg || fire);

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            in_byte_reg <= '0;
            in_fin_reg  <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_vld_reg  <= 1'b1;
            in_byte_reg <= s_axis_tdata;
            in_fin_reg  <= s_axis_tlast;
        end
        else if (fire)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    lsed_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hash_size (hash_size),
        .first_seq (first_seq),
        .first_mod (first_mod),
        .busy      (cfg_busy)
    );

    lsed_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (fire),
        .data_byte  (in_byte_reg),
        .final_byte (in_fin_reg),
        .hash_size  (hash_size),
        .first_seq  (first_seq),
        .first_mod  (first_mod),
        .res_a      (res_a),
        .res_b      (res_b),
        .res_cnt    (res_cnt)
    );

    lsed_outq #(
        .DEPTH (OUTQ_DEPTH)
    ) u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_a     (res_a),
        .wr_b     (res_b),
        .wr_cnt   (res_cnt),
        .room2    (room2),
        .rd_data  (head),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready)
    );

    // Output packing.
    assign m_axis_tdata = {(TDATA_W - FIELDS_W)'(0), head.err, head.payload, head.seq,
                           head.hashed, head.entry_size, head.entry_type};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

    // Checks.
    `LSED_ASSERT_SAME(a_err_code_matches_kind, m_axis_tvalid,
        ((head.kind == KIND_ERROR) == (head.err != ERR_NONE)),
        "error code and result kind disagree")
    `LSED_ASSERT_NEXT(a_seq_write_blocks_input,
        cfg_valid && cfg_ready && cfg_index == REG_FIRST_SEQ, !s_axis_tready,
        "input taken during start sequence residue sweep")
    `LSED_ASSERT_NEXT(a_input_reg_holds, in_vld_reg && !fire,
        in_vld_reg && $stable(in_byte_reg) && $stable(in_fin_reg),
        "pending input byte lost or overwritten")

endmodule
